// ===== rtl/tcaq_pkg.sv =====
package tcaq_pkg;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } ctrl_state_t;

    localparam logic REQ_ADMIT  = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    localparam logic signed [1:0] KIND_ANY = 2'sb00;
    localparam logic signed [1:0] KIND_POS = 2'sb01;
    localparam logic signed [1:0] KIND_NEG = 2'sb11;

    typedef struct packed {
        logic load;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic emit;
        logic out_free;
    } dp_status_t;

endpackage

// ===== rtl/tcaq_ctrl.sv =====
module tcaq_ctrl
    import tcaq_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (!status.emit || status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready    = 1'b0;
        cmd.load   = 1'b0;
        cmd.commit = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_EXEC: begin
                cmd.commit = !status.emit || status.out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== rtl/tcaq_dp.sv =====
module tcaq_dp
    import tcaq_pkg::*;
#(
    parameter int QUEUE_DEPTH,
    parameter int ID_BITS
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_req_type,
    input  logic signed [ID_BITS-1:0] s_animal_id,
    input  logic signed [1:0]         s_wanted_kind,
    input  logic                      m_ready,
    output logic                      m_valid,
    output logic signed [ID_BITS-1:0] m_removed_id,
    input  ctrl_cmd_t                 cmd,
    output dp_status_t                status
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int ENT_W = ID_BITS + CNT_W;
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    logic [ENT_W-1:0] pos_mem [QUEUE_DEPTH];
    logic [ENT_W-1:0] neg_mem [QUEUE_DEPTH];

    logic                      req_reg;
    logic signed [ID_BITS-1:0] id_reg;
    logic signed [1:0]         kind_reg;
    logic [ENT_W-1:0]          pos_rd_reg;
    logic [ENT_W-1:0]          neg_rd_reg;

    logic [PTR_W-1:0] pos_head_reg, pos_head_next;
    logic [PTR_W-1:0] pos_tail_reg, pos_tail_next;
    logic [CNT_W-1:0] pos_cnt_reg, pos_cnt_next;
    logic [CNT_W-1:0] pos_adm_reg, pos_adm_next;
    logic [PTR_W-1:0] neg_head_reg, neg_head_next;
    logic [PTR_W-1:0] neg_tail_reg, neg_tail_next;
    logic [CNT_W-1:0] neg_cnt_reg, neg_cnt_next;
    logic [CNT_W-1:0] neg_adm_reg, neg_adm_next;
    logic             pos_older_reg, pos_older_next;
    logic             m_valid_reg, m_valid_next;
    logic signed [ID_BITS-1:0] m_id_reg, m_id_next;

    logic             is_admit;
    logic             pos_empty;
    logic             neg_empty;
    logic             adm_pos;
    logic             adm_neg;
    logic             take_pos;
    logic             take_neg;
    logic [CNT_W-1:0] pos_pop_after;
    logic [CNT_W-1:0] neg_pop_after;
    logic [CNT_W-1:0] pos_snap;
    logic [CNT_W-1:0] neg_snap;
    logic [CNT_W-1:0] pos_gap;
    logic [CNT_W-1:0] neg_gap;

    assign is_admit  = (req_reg == REQ_ADMIT);
    assign pos_empty = (pos_cnt_reg == '0);
    assign neg_empty = (neg_cnt_reg == '0);
    assign adm_pos   = is_admit && (id_reg != '0) && !id_reg[ID_BITS-1]
                       && (pos_cnt_reg != FULL_CNT);
    assign adm_neg   = is_admit && id_reg[ID_BITS-1] && (neg_cnt_reg != FULL_CNT);

    always_comb begin
        take_pos = 1'b0;
        take_neg = 1'b0;
        if (!is_admit) begin
            case (kind_reg)
                KIND_ANY: begin
                    if (!pos_empty && (neg_empty || pos_older_reg)) begin
                        take_pos = 1'b1;
                    end else if (!neg_empty) begin
                        take_neg = 1'b1;
                    end
                end
                KIND_POS: begin
                    take_pos = !pos_empty;
                end
                KIND_NEG: begin
                    take_neg = !neg_empty;
                end
                default: begin
                    take_pos = 1'b0;
                end
            endcase
        end
    end

    assign pos_snap      = pos_rd_reg[CNT_W-1:0];
    assign neg_snap      = neg_rd_reg[CNT_W-1:0];
    assign pos_pop_after = pos_adm_reg - pos_cnt_reg + CNT_ONE;
    assign neg_pop_after = neg_adm_reg - neg_cnt_reg + CNT_ONE;
    assign pos_gap       = neg_snap - pos_pop_after;
    assign neg_gap       = pos_snap - neg_pop_after;

    assign status.emit     = take_pos || take_neg;
    assign status.out_free = !m_valid_reg || m_ready;

    always_comb begin
        pos_head_next  = pos_head_reg;
        pos_tail_next  = pos_tail_reg;
        pos_cnt_next   = pos_cnt_reg;
        pos_adm_next   = pos_adm_reg;
        neg_head_next  = neg_head_reg;
        neg_tail_next  = neg_tail_reg;
        neg_cnt_next   = neg_cnt_reg;
        neg_adm_next   = neg_adm_reg;
        pos_older_next = pos_older_reg;
        if (cmd.commit) begin
            if (adm_pos) begin
                pos_tail_next = (pos_tail_reg == LAST_PTR) ? '0 : pos_tail_reg + 1'b1;
                pos_cnt_next  = pos_cnt_reg + CNT_ONE;
                pos_adm_next  = pos_adm_reg + CNT_ONE;
                if (pos_empty) begin
                    pos_older_next = 1'b0;
                end
            end
            if (adm_neg) begin
                neg_tail_next = (neg_tail_reg == LAST_PTR) ? '0 : neg_tail_reg + 1'b1;
                neg_cnt_next  = neg_cnt_reg + CNT_ONE;
                neg_adm_next  = neg_adm_reg + CNT_ONE;
                if (neg_empty) begin
                    pos_older_next = 1'b1;
                end
            end
            if (take_pos) begin
                pos_head_next = (pos_head_reg == LAST_PTR) ? '0 : pos_head_reg + 1'b1;
                pos_cnt_next  = pos_cnt_reg - CNT_ONE;
                if (pos_older_reg && !neg_empty) begin
                    pos_older_next = (pos_gap != '0);
                end
            end
            if (take_neg) begin
                neg_head_next = (neg_head_reg == LAST_PTR) ? '0 : neg_head_reg + 1'b1;
                neg_cnt_next  = neg_cnt_reg - CNT_ONE;
                if (!pos_older_reg && !pos_empty) begin
                    pos_older_next = (neg_gap == '0);
                end
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_id_next    = m_id_reg;
        if (cmd.commit && status.emit) begin
            m_valid_next = 1'b1;
            m_id_next    = take_pos ? pos_rd_reg[ENT_W-1:CNT_W] : neg_rd_reg[ENT_W-1:CNT_W];
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_head_reg  <= '0;
            pos_tail_reg  <= '0;
            pos_cnt_reg   <= '0;
            pos_adm_reg   <= '0;
            neg_head_reg  <= '0;
            neg_tail_reg  <= '0;
            neg_cnt_reg   <= '0;
            neg_adm_reg   <= '0;
            pos_older_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            pos_head_reg  <= pos_head_next;
            pos_tail_reg  <= pos_tail_next;
            pos_cnt_reg   <= pos_cnt_next;
            pos_adm_reg   <= pos_adm_next;
            neg_head_reg  <= neg_head_next;
            neg_tail_reg  <= neg_tail_next;
            neg_cnt_reg   <= neg_cnt_next;
            neg_adm_reg   <= neg_adm_next;
            pos_older_reg <= pos_older_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_id_reg <= m_id_next;
        if (cmd.load) begin
            req_reg  <= s_req_type;
            id_reg   <= s_animal_id;
            kind_reg <= s_wanted_kind;
        end
    end

    // tag each entry with the other kind's admit count
    always_ff @(posedge aclk) begin
        if (cmd.commit && adm_pos) begin
            pos_mem[pos_tail_reg] <= {id_reg, neg_adm_reg};
        end
        if (cmd.commit && adm_neg) begin
            neg_mem[neg_tail_reg] <= {id_reg, pos_adm_reg};
        end
        pos_rd_reg <= pos_mem[pos_head_reg];
        neg_rd_reg <= neg_mem[neg_head_reg];
    end

    assign m_valid      = m_valid_reg;
    assign m_removed_id = m_id_reg;

endmodule

// ===== rtl/two_class_age_ordered_queue_core.sv =====
// Age-ordered queue for two kinds of identifiers.
// Input channel (s_valid/s_ready): s_req_type selects admit or remove. An admit
// stores s_animal_id at the tail of its kind (positive or negative); a zero id or
// an admit to a full kind is dropped. A remove takes the oldest entry of either
// kind (s_wanted_kind 0) or of the named kind (1 positive, -1 negative).
// Result channel (m_valid/m_ready): one beat carrying m_removed_id for each
// remove that finds an entry; all other requests produce no beat.
// An accepted request is latched, runs in the EXEC state and writes its result
// to the output register; no new request is taken until it finishes, so that the
// registered head read of each kind's entry memory settles after each update.
// When the receiver stalls, one result waits in the output register; a later
// remove that finds an entry holds in execution until that beat is taken.
// Reset empties both kinds and drops any pending result; entry memories are
// not cleared and the block takes requests in the first cycle after reset.
module two_class_age_ordered_queue_core
    import tcaq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_req_type,
    input  logic signed [ID_BITS-1:0] s_animal_id,
    input  logic signed [1:0]         s_wanted_kind,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [ID_BITS-1:0] m_removed_id
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    tcaq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    tcaq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_BITS     (ID_BITS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_req_type    (s_req_type),
        .s_animal_id   (s_animal_id),
        .s_wanted_kind (s_wanted_kind),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_removed_id  (m_removed_id),
        .cmd           (cmd),
        .status        (status)
    );

endmodule

// ===== rtl/tcaq_checker.sv =====
module tcaq_checker #(
    parameter int ID_BITS
) (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_valid,
    input logic                      s_ready,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic signed [ID_BITS-1:0] m_removed_id
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_removed_id))
        else $error("result beat changed while stalled");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while previous one still executing");

    a_nonzero_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_removed_id != '0)
        else $error("zero identifier emitted");

    a_result_from_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result appeared without an executing request");

endmodule

bind two_class_age_ordered_queue_core tcaq_checker #(
    .ID_BITS (ID_BITS)
) u_tcaq_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_removed_id (m_removed_id)
);

// ===== test/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tcaq_pkg::*;

    localparam int DEPTH      = 16;
    localparam int ID_W       = 16;
    localparam int QUIET_TAIL = 100;
    localparam int STALL_MAX  = 2000;

    localparam logic signed [1:0] KIND_UNDEF = 2'sb10;

    typedef struct packed {
        logic                   req;
        logic signed [ID_W-1:0] id;
        logic signed [1:0]      kind;
    } shelter_req_t;

    typedef struct {
        logic signed [ID_W-1:0] id;
        int unsigned            stamp;
    } pen_entry_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    logic                   s_req_type;
    logic signed [ID_W-1:0] s_animal_id;
    logic signed [1:0]      s_wanted_kind;
    logic                   m_valid;
    logic                   m_ready;
    logic signed [ID_W-1:0] m_removed_id;

    shelter_req_t           pending[$];
    pen_entry_t             pos_pen[$];
    pen_entry_t             neg_pen[$];
    logic signed [ID_W-1:0] removed_expect[$];
    int unsigned            arrivals = 0;
    int                     errors = 0;
    int                     send_gap = 0;
    int                     recv_gap = 0;
    int                     idle_odds = 2;
    int                     stall_odds = 2;
    int                     quiet_cycles = 0;

    two_class_age_ordered_queue_core #(
        .QUEUE_DEPTH(DEPTH),
        .ID_BITS    (ID_W)
    ) i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_animal_id  (s_animal_id),
        .s_wanted_kind(s_wanted_kind),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_removed_id (m_removed_id)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        errors++;
    endtask

    task automatic shelter_step(input logic req, input logic signed [ID_W-1:0] id,
                                input logic signed [1:0] kind);
        pen_entry_t ent;
        logic       take_pos;
        ent.id = id;
        ent.stamp = arrivals;
        if (req == REQ_ADMIT) begin
            if (id == '0) return;
            if (!id[ID_W-1]) begin
                if (pos_pen.size() >= DEPTH) return;
                pos_pen.push_back(ent);
            end else begin
                if (neg_pen.size() >= DEPTH) return;
                neg_pen.push_back(ent);
            end
            arrivals++;
            return;
        end
        case (kind)
            KIND_ANY: begin
                if (pos_pen.size() == 0 && neg_pen.size() == 0) return;
                if (pos_pen.size() == 0) take_pos = 1'b0;
                else if (neg_pen.size() == 0) take_pos = 1'b1;
                else take_pos = pos_pen[0].stamp < neg_pen[0].stamp;
            end
            KIND_POS: begin
                if (pos_pen.size() == 0) return;
                take_pos = 1'b1;
            end
            KIND_NEG: begin
                if (neg_pen.size() == 0) return;
                take_pos = 1'b0;
            end
            default: return;
        endcase
        if (take_pos) removed_expect.push_back(pos_pen.pop_front().id);
        else removed_expect.push_back(neg_pen.pop_front().id);
    endtask

    function automatic void add_req(input logic req, input logic signed [ID_W-1:0] id,
                                    input logic signed [1:0] kind);
        shelter_req_t r;
        r.req = req;
        r.id = id;
        r.kind = kind;
        pending.push_back(r);
    endfunction

    function automatic logic signed [1:0] pick_kind();
        int k;
        k = $urandom_range(0, 15);
        if (k == 0) return KIND_UNDEF;
        if (k <= 5) return KIND_ANY;
        if (k <= 10) return KIND_POS;
        return KIND_NEG;
    endfunction

    // drive the request channel; predict each accepted beat
    always @(posedge aclk) begin
        shelter_req_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                shelter_step(s_req_type, s_animal_id, s_wanted_kind);
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (pending.size() > QUIET_TAIL && idle_odds != 0
                             && $urandom_range(0, 15) < idle_odds * 2) begin
                    send_gap = $urandom_range(0, 17);
                    s_valid <= 1'b0;
                end else if (pending.size() != 0) begin
                    nxt = pending.pop_front();
                    if ($urandom_range(0, 39) == 0) idle_odds = $urandom_range(0, 3);
                    s_valid <= 1'b1;
                    s_req_type <= nxt.req;
                    s_animal_id <= nxt.id;
                    s_wanted_kind <= nxt.kind;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // check result beats and stall the result channel
    always @(posedge aclk) begin
        logic signed [ID_W-1:0] want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (removed_expect.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat removed_id=%0d", m_removed_id));
                end else begin
                    want = removed_expect.pop_front();
                    if (m_removed_id !== want)
                        report_mismatch($sformatf("removed_id=%0d, want %0d",
                                                  m_removed_id, want));
                end
            end
            if (recv_gap > 0) begin
                recv_gap--;
                m_ready <= 1'b0;
            end else if (pending.size() > QUIET_TAIL && stall_odds != 0
                         && $urandom_range(0, 15) < stall_odds * 2) begin
                recv_gap = $urandom_range(0, 17);
                if ($urandom_range(0, 7) == 0) stall_odds = $urandom_range(0, 3);
                m_ready <= 1'b0;
            end else begin
                if ($urandom_range(0, 39) == 0) stall_odds = $urandom_range(0, 3);
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles == STALL_MAX) begin
                    $display("Test completed with failures");
                    $finish;
                end
            end
        end
    end

    initial begin
        int   run_len;
        int   admit_pct;
        int   n;
        logic signed [ID_W-1:0] rid;

        aresetn = 1'b0;
        s_valid = 1'b0;
        s_req_type = REQ_ADMIT;
        s_animal_id = '0;
        s_wanted_kind = KIND_ANY;
        m_ready = 1'b0;

        // empty store, zero id, extreme ids, unknown kind, age order across kinds
        add_req(REQ_REMOVE, ID_W'($urandom), KIND_ANY);
        add_req(REQ_REMOVE, ID_W'($urandom), KIND_POS);
        add_req(REQ_REMOVE, ID_W'($urandom), KIND_NEG);
        add_req(REQ_REMOVE, ID_W'($urandom), KIND_UNDEF);
        add_req(REQ_ADMIT, 16'sd0, KIND_POS);
        add_req(REQ_ADMIT, 16'sd32767, KIND_UNDEF);
        add_req(REQ_ADMIT, -16'sd32768, KIND_NEG);
        add_req(REQ_ADMIT, 16'sd1, KIND_ANY);
        add_req(REQ_ADMIT, -16'sd1, KIND_POS);
        add_req(REQ_REMOVE, ID_W'($urandom), KIND_UNDEF);
        add_req(REQ_REMOVE, 16'sd0, KIND_ANY);
        add_req(REQ_REMOVE, ID_W'($urandom), KIND_NEG);
        add_req(REQ_REMOVE, ID_W'($urandom), KIND_ANY);
        add_req(REQ_REMOVE, ID_W'($urandom), KIND_POS);
        add_req(REQ_REMOVE, ID_W'($urandom), KIND_ANY);
        add_req(REQ_ADMIT, -16'sd21846, KIND_ANY);
        add_req(REQ_ADMIT, 16'sd21845, KIND_NEG);
        add_req(REQ_ADMIT, -16'sd2, KIND_POS);
        add_req(REQ_ADMIT, 16'sd2, KIND_UNDEF);
        add_req(REQ_REMOVE, -16'sd1, KIND_ANY);
        add_req(REQ_REMOVE, 16'sd32767, KIND_POS);
        add_req(REQ_REMOVE, ID_W'($urandom), KIND_ANY);
        add_req(REQ_REMOVE, ID_W'($urandom), KIND_ANY);

        // runs that fill, churn or drain the store
        n = 0;
        while (n < 1030) begin
            run_len = $urandom_range(8, 48);
            case ($urandom_range(0, 2))
                0: admit_pct = 85;
                1: admit_pct = 50;
                default: admit_pct = 15;
            endcase
            repeat (run_len) begin
                if ($urandom_range(0, 99) < admit_pct) begin
                    rid = ID_W'($urandom);
                    if ($urandom_range(0, 31) == 0) rid = '0;
                    add_req(REQ_ADMIT, rid, 2'($urandom));
                end else begin
                    add_req(REQ_REMOVE, ID_W'($urandom), pick_kind());
                end
                n++;
            end
        end

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        do @(negedge aclk); while (pending.size() != 0 || s_valid);
        do @(negedge aclk); while (removed_expect.size() != 0);
        repeat (20) @(negedge aclk);

        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== two_class_age_ordered_queue_core.f =====
rtl/tcaq_pkg.sv
rtl/tcaq_ctrl.sv
rtl/tcaq_dp.sv
rtl/two_class_age_ordered_queue_core.sv
rtl/tcaq_checker.sv
test/testbench.sv
